[hdl/gbs_pkg.sv]
// shared types, constants and the overlap test for the box suppression block
package gbs_pkg;

  localparam int MAX_KEPT_DEF = 64;
  localparam int ADDR_W = 3;
  localparam logic [16:0] IOU_THRESHOLD_RESET = 17'd32768;

  // register word indexes on the config port
  localparam logic REG_IOU_THRESHOLD = 1'b0;

  typedef struct packed {
    logic              frame_start;
    logic signed [11:0] box_left;
    logic signed [11:0] box_top;
    logic [10:0]       box_width;
    logic [10:0]       box_height;
  } gbs_req_t;

  typedef struct packed {
    logic       keep;
    logic [5:0] kept_slot;
    logic       list_full;
  } gbs_res_t;

  // one kept box as held in a cell
  typedef struct packed {
    logic signed [11:0] left;
    logic signed [11:0] top;
    logic [10:0]       width;
    logic [10:0]       height;
    logic [21:0]       area;
  } box_t;

  // probe box plus the pending overlap test of the previous cell
  typedef struct packed {
    logic signed [11:0] left;
    logic signed [11:0] top;
    logic [10:0]       width;
    logic [10:0]       height;
    logic [21:0]       area;
    logic              keep;
    logic [21:0]       inter;
    logic [22:0]       uni;
  } stage_t;

  typedef struct packed {
    logic active;
    logic load;
  } cell_ctrl_t;

  // intersection * 65536 > threshold * union
  function automatic logic over_thr(logic [21:0] inter, logic [22:0] uni,
                                    logic [16:0] thr);
    logic [39:0] lhs;
    logic [39:0] rhs;
    lhs = {2'b00, inter, 16'h0000};
    rhs = thr * uni;
    return lhs > rhs;
  endfunction

endpackage

[hdl/greedy_box_suppression.sv]
// top level of the greedy box suppression block
//
// Class-agnostic greedy non-maximum suppression. Boxes come in one per
// request, already sorted by falling score; each is tested against every
// box on the kept list and is suppressed when intersection * 65536 exceeds
// iou_threshold * union. A request is taken when start is high and busy is
// low; frame_start empties the kept list first. The probe box walks a row of
// MAX_KEPT cells, one cell per clock: the request is registered as the probe,
// the probe passes through the cells, and the last cell's overlap gets its
// final test and the list update as the result is registered. The result
// shows on result for exactly one cycle with done high; busy is low in that
// same cycle. There is no flow control on the result side, so the receiver
// must take every result as it appears. A suppressed box reports
// kept_slot 0; a survivor that finds the list full reports keep and
// list_full with slot 0 and is not stored.
module greedy_box_suppression #(
  parameter int MAX_KEPT = gbs_pkg::MAX_KEPT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  gbs_pkg::gbs_req_t          request,
  output logic                       busy,
  output logic                       done,
  output gbs_pkg::gbs_res_t          result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gbs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import gbs_pkg::*;

  localparam int CntW = $clog2(MAX_KEPT + 1);

  // config register
  logic [16:0] thr;

  // request side
  logic        accept;
  logic        busy_q;
  logic        stage0_valid;
  stage_t      stage0;

  // kept list fill level
  logic [CntW-1:0] count;

  // cell row, element k feeds cell k
  logic        chain_valid [MAX_KEPT+1];
  stage_t      chain       [MAX_KEPT+1];
  cell_ctrl_t  ctrl        [MAX_KEPT];
  box_t        wr_box;

  // end of the row
  stage_t      tail;
  logic        tail_fire;
  logic        keep_final;
  logic        has_room;
  logic        store_fire;
  logic        done_q;
  gbs_res_t    result_q;

  // apb: always ready, write on the access phase
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IOU_THRESHOLD) ? 32'(thr) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= IOU_THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_IOU_THRESHOLD) begin
      thr <= pwdata[16:0];
    end
  end

  assign accept = start && !busy_q;

  // busy from acceptance until the result cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q <= 1'b0;
    end else if (accept) begin
      busy_q <= 1'b1;
    end else if (tail_fire) begin
      busy_q <= 1'b0;
    end
  end

  // probe load: area computed once here, nothing pending yet
  always_ff @(posedge clk) begin
    if (rst) begin
      stage0_valid <= 1'b0;
    end else begin
      stage0_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage0.left   <= request.box_left;
      stage0.top    <= request.box_top;
      stage0.width  <= request.box_width;
      stage0.height <= request.box_height;
      stage0.area   <= request.box_width * request.box_height;
      stage0.keep   <= 1'b1;
      stage0.inter  <= 22'd0;
      stage0.uni    <= 23'd0;
    end
  end

  assign chain_valid[0] = stage0_valid;
  assign chain[0]       = stage0;

  // write data for the slot that takes a survivor
  assign wr_box.left   = tail.left;
  assign wr_box.top    = tail.top;
  assign wr_box.width  = tail.width;
  assign wr_box.height = tail.height;
  assign wr_box.area   = tail.area;

  genvar k;
  generate
    for (k = 0; k < MAX_KEPT; k++) begin : g_cell
      // only slots below the fill level take part in the test
      assign ctrl[k].active = CntW'(k) < count;
      assign ctrl[k].load   = store_fire && (count == CntW'(k));

      gbs_cell u_cell (
        .clk             (clk),
        .rst             (rst),
        .ctrl            (ctrl[k]),
        .wr_box          (wr_box),
        .thr             (thr),
        .probe_valid_in  (chain_valid[k]),
        .probe_in        (chain[k]),
        .probe_valid_out (chain_valid[k+1]),
        .probe_out       (chain[k+1])
      );
    end
  endgenerate

  // last cell's overlap still needs its threshold test
  assign tail       = chain[MAX_KEPT];
  assign tail_fire  = chain_valid[MAX_KEPT];
  assign keep_final = tail.keep && !over_thr(tail.inter, tail.uni, thr);
  assign has_room   = count < CntW'(MAX_KEPT);
  assign store_fire = tail_fire && keep_final && has_room;

  // fill level: cleared by frame start, bumped when a survivor is stored
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept && request.frame_start) begin
      count <= '0;
    end else if (store_fire) begin
      count <= count + 1'b1;
    end
  end

  // result strobe and payload
  always_ff @(posedge clk) begin
    if (rst) begin
      done_q <= 1'b0;
    end else begin
      done_q <= tail_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (tail_fire) begin
      result_q.keep      <= keep_final;
      result_q.kept_slot <= store_fire ? 6'(count) : 6'd0;
      result_q.list_full <= keep_final && !has_room;
    end
  end

  assign busy   = busy_q;
  assign done   = done_q;
  assign result = result_q;

endmodule

[hdl/gbs_cell.sv]
// one kept-box cell: stores a box and tests the passing probe against it
module gbs_cell (
  input  logic                clk,
  input  logic                rst,
  input  gbs_pkg::cell_ctrl_t ctrl,
  input  gbs_pkg::box_t       wr_box,
  input  logic [16:0]         thr,
  input  logic                probe_valid_in,
  input  gbs_pkg::stage_t     probe_in,
  output logic                probe_valid_out,
  output gbs_pkg::stage_t     probe_out
);
  import gbs_pkg::*;

  box_t               box;
  stage_t             probe;
  logic               valid;
  logic signed [12:0] p_right, p_bottom, k_right, k_bottom;
  logic signed [11:0] x0, y0;
  logic signed [12:0] x1, y1;
  logic signed [13:0] dx, dy;
  logic               hit;
  logic [21:0]        inter;
  stage_t             probe_next;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      box <= wr_box;
    end
  end

  always_comb begin
    p_right  = $signed({probe_in.left[11], probe_in.left}) + $signed({2'b00, probe_in.width});
    p_bottom = $signed({probe_in.top[11], probe_in.top}) + $signed({2'b00, probe_in.height});
    k_right  = $signed({box.left[11], box.left}) + $signed({2'b00, box.width});
    k_bottom = $signed({box.top[11], box.top}) + $signed({2'b00, box.height});
    x0 = (probe_in.left > box.left) ? probe_in.left : box.left;
    y0 = (probe_in.top > box.top) ? probe_in.top : box.top;
    x1 = (p_right < k_right) ? p_right : k_right;
    y1 = (p_bottom < k_bottom) ? p_bottom : k_bottom;
    dx = $signed({x1[12], x1}) - $signed({{2{x0[11]}}, x0});
    dy = $signed({y1[12], y1}) - $signed({{2{y0[11]}}, y0});
    // overlap side never exceeds the probe side, so 11 bits hold it
    hit   = ctrl.active && (dx > 14'sd0) && (dy > 14'sd0);
    inter = hit ? dx[10:0] * dy[10:0] : 22'd0;

    probe_next       = probe_in;
    probe_next.keep  = probe_in.keep && !over_thr(probe_in.inter, probe_in.uni, thr);
    probe_next.inter = inter;
    // an empty slot hands on a zero union, so its test never fires
    probe_next.uni   = ctrl.active ? 23'(probe_in.area) + 23'(box.area) - 23'(inter)
                                   : 23'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= probe_valid_in;
    end
  end

  always_ff @(posedge clk) begin
    probe <= probe_next;
  end

  assign probe_valid_out = valid;
  assign probe_out       = probe;

endmodule

[hdl/gbs_checker.sv]
// port-level checks for the box suppression block, bound to the top level
module gbs_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input gbs_pkg::gbs_res_t result
);
  import gbs_pkg::*;

  // an accepted request holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but busy did not rise");

  // a result only ends a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("result without a request in flight");

  // full-list flag only for survivors, with slot zero
  a_full_kept: assert property (@(posedge clk) disable iff (rst)
    done && result.list_full |-> result.keep && result.kept_slot == 6'd0)
    else $error("list full reported on a suppressed box or with a slot");

  // suppressed box reports nothing else
  a_suppressed_clean: assert property (@(posedge clk) disable iff (rst)
    done && !result.keep |-> result.kept_slot == 6'd0 && !result.list_full)
    else $error("suppressed box reports a slot or list full");

endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

[test/greedy_box_suppression_checker.sv]
// checker for the greedy box suppression block: tracks the kept list and compares every result
module greedy_box_suppression_checker #(
  parameter int KEPT_DEPTH = gbs_pkg::MAX_KEPT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  gbs_pkg::gbs_req_t          request,
  input  logic                       done,
  input  gbs_pkg::gbs_res_t          result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gbs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic [31:0]                prdata,
  input  logic                       pready,
  output int                         fail_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import gbs_pkg::*;

  localparam logic [ADDR_W-1:0] THR_ADDR = ADDR_W'(4 * REG_IOU_THRESHOLD);

  // shadow copy of the kept list
  logic signed [11:0] list_left   [KEPT_DEPTH];
  logic signed [11:0] list_top    [KEPT_DEPTH];
  logic [10:0]        list_width  [KEPT_DEPTH];
  logic [10:0]        list_height [KEPT_DEPTH];
  longint unsigned    list_area   [KEPT_DEPTH];
  int                 list_count;
  logic [16:0]        thr_now;
  gbs_res_t           verdict_q[$];

  task automatic note_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // runs one box against the kept list and updates it
  function automatic gbs_res_t judge_box(input gbs_req_t b);
    int l, t, w, h, kl, kt, kw, kh, x0, y0, x1, y1, k;
    longint unsigned area, inter, uni, thr_wide;
    gbs_res_t r;
    l = b.box_left;
    t = b.box_top;
    w = b.box_width;
    h = b.box_height;
    area = longint'(w) * longint'(h);
    thr_wide = thr_now;
    r = '0;
    r.keep = 1'b1;
    if (b.frame_start) list_count = 0;
    for (k = 0; k < list_count; k++) begin
      kl = list_left[k];
      kt = list_top[k];
      kw = list_width[k];
      kh = list_height[k];
      x0 = (l > kl) ? l : kl;
      y0 = (t > kt) ? t : kt;
      x1 = (l + w < kl + kw) ? l + w : kl + kw;
      y1 = (t + h < kt + kh) ? t + h : kt + kh;
      inter = (x1 > x0 && y1 > y0) ? longint'(x1 - x0) * longint'(y1 - y0) : 0;
      uni = area + list_area[k] - inter;
      if ((inter << 16) > thr_wide * uni) r.keep = 1'b0;
    end
    if (r.keep) begin
      if (list_count < KEPT_DEPTH) begin
        list_left[list_count]   = b.box_left;
        list_top[list_count]    = b.box_top;
        list_width[list_count]  = b.box_width;
        list_height[list_count] = b.box_height;
        list_area[list_count]   = area;
        r.kept_slot = 6'(list_count);
        list_count++;
      end else begin
        r.list_full = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    gbs_res_t want;
    if (rst) begin
      verdict_q.delete();
      list_count = 0;
      thr_now = IOU_THRESHOLD_RESET;
      fail_count = 0;
      pending = 0;
    end else begin
      if (done) begin
        if (verdict_q.size() == 0) begin
          note_mismatch($sformatf("result keep=%0d slot=%0d full=%0d with none expected",
                                  result.keep, result.kept_slot, result.list_full));
        end else begin
          want = verdict_q.pop_front();
          if (result.keep !== want.keep || result.kept_slot !== want.kept_slot ||
              result.list_full !== want.list_full)
            note_mismatch($sformatf("expected keep=%0d slot=%0d full=%0d, got keep=%0d slot=%0d full=%0d",
                                    want.keep, want.kept_slot, want.list_full,
                                    result.keep, result.kept_slot, result.list_full));
        end
      end
      if (start && !busy) verdict_q = {verdict_q, judge_box(request)};
      if (psel && penable && pready && paddr == THR_ADDR) begin
        if (pwrite)
          thr_now = pwdata[16:0];
        else if (prdata !== 32'(thr_now))
          note_mismatch($sformatf("threshold read expected %0d, got %0d", thr_now, prdata));
      end
      pending = verdict_q.size();
    end
  end

endmodule

[test/greedy_box_suppression_tb.sv]
// testbench top for the greedy box suppression block: stimulus, config writes and verdict
module greedy_box_suppression_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gbs_pkg::*;

  localparam int RUN_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 175;
  localparam int REQ_BITS = $bits(gbs_req_t);
  localparam logic [ADDR_W-1:0] THR_ADDR = ADDR_W'(4 * REG_IOU_THRESHOLD);

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  gbs_req_t          request = '0;
  logic              busy;
  logic              done;
  gbs_res_t          result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int idle_pct = 0;

  always #5 clk = ~clk;

  greedy_box_suppression u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  greedy_box_suppression_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .done       (done),
    .result     (result),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int fit(input int v, input int lo, input int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // builds a request, clamping coordinates and sizes into field range
  function automatic gbs_req_t make_box(input bit fs, input int l, input int t,
                                        input int w, input int h);
    gbs_req_t b;
    b.frame_start = fs;
    b.box_left    = 12'(fit(l, -2048, 2047));
    b.box_top     = 12'(fit(t, -2048, 2047));
    b.box_width   = 11'(fit(w, 0, 2047));
    b.box_height  = 11'(fit(h, 0, 2047));
    return b;
  endfunction

  // every tb task is entered and left at a falling edge, so inputs only move there

  // one request; start stays high across back-to-back requests
  task automatic issue_box(input gbs_req_t b);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      // gap long enough to land anywhere in the block's walk, or past its end
      repeat ($urandom_range(1, 80)) @(negedge clk);
    end
    start   <= 1'b1;
    request <= b;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // drop start and wait until every expected result has shown up
  task automatic settle();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= THR_ADDR;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // write the threshold and read it back; the checker compares the readback
  task automatic set_threshold(input logic [16:0] thr);
    settle();
    apb_access(1'b1, 32'(thr));
    apb_access(1'b0, 32'h0);
  endtask

  // one frame of boxes: clusters of near-duplicates, fresh boxes, a little noise;
  // tiled frames lay disjoint boxes on a 9x9 grid so the list fills up
  task automatic run_frame(input int len, input bit tiled, input bit opens);
    int cl[3], ct[3], cw[3], ch[3];
    int ncl, c, j, k, g, l, t, w, h;
    gbs_req_t b;
    ncl = $urandom_range(1, 3);
    for (c = 0; c < ncl; c++) begin
      cw[c] = $urandom_range(4, 600);
      ch[c] = $urandom_range(4, 600);
      cl[c] = int'($urandom_range(4095)) - 2048;
      ct[c] = int'($urandom_range(4095)) - 2048;
    end
    for (k = 0; k < len; k++) begin
      if ($urandom_range(99) < 8) begin
        // noise: every field and every bit uniformly random
        b = REQ_BITS'({$urandom(), $urandom()});
      end else begin
        if (tiled) begin
          g = k % 81;
          w = $urandom_range(1, 420);
          h = $urandom_range(1, 420);
          l = -2048 + (g % 9) * 450 + int'($urandom_range(20));
          t = -2048 + (g / 9) * 450 + int'($urandom_range(20));
        end else if ($urandom_range(99) < 70) begin
          // jittered copy of a cluster center, overlap ratio spread around the limit
          c = $urandom_range(ncl - 1);
          j = cw[c] / 4 + 1;
          l = cl[c] + int'($urandom_range(2 * j)) - j;
          w = cw[c] + int'($urandom_range(2 * j)) - j;
          j = ch[c] / 4 + 1;
          t = ct[c] + int'($urandom_range(2 * j)) - j;
          h = ch[c] + int'($urandom_range(2 * j)) - j;
        end else begin
          l = int'($urandom_range(4095)) - 2048;
          t = int'($urandom_range(4095)) - 2048;
          w = $urandom_range(0, 250);
          h = $urandom_range(0, 250);
        end
        b = make_box(opens && k == 0, l, t, w, h);
      end
      issue_box(b);
    end
  endtask

  initial begin
    int p, items, len;
    logic [16:0] thr;
    bit tiled;

    // synchronous reset, released at a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset value of the threshold
    apb_access(1'b0, 32'h0);

    // directed part at the reset threshold of one half
    issue_box(make_box(1, -2048, -2048, 2047, 2047));  // most negative corner, biggest box
    issue_box(make_box(0, -2048, -2048, 2047, 2047));  // exact duplicate, suppressed
    issue_box(make_box(0, 2047, 2047, 2047, 2047));    // far corner, no overlap
    issue_box(make_box(0, 0, 0, 0, 0));                // empty box
    issue_box(make_box(0, 0, 0, 0, 0));                // empty against empty: zero union, kept
    issue_box(make_box(0, 0, 0, 10, 10));
    issue_box(make_box(0, 10, 0, 10, 10));             // shares an edge only, no overlap
    issue_box(make_box(0, 5, 0, 10, 10));              // one third overlap with both, kept
    issue_box(make_box(0, 0, 0, 10, 10));              // duplicate, suppressed
    issue_box(make_box(0, 100, 100, 10, 10));
    issue_box(make_box(0, 100, 100, 10, 5));           // ratio exactly at the limit, kept
    issue_box(make_box(0, 100, 100, 10, 4));           // inside the half box, 0.8 there, suppressed
    issue_box(make_box(0, 300, 300, 10, 10));
    issue_box(make_box(0, 300, 300, 10, 6));           // just above, suppressed
    issue_box(make_box(1, 100, 100, 10, 10));          // new frame empties the list: slot 0

    // zero threshold: any real overlap suppresses
    set_threshold(17'd0);
    issue_box(make_box(1, 0, 0, 4, 4));
    issue_box(make_box(0, 3, 3, 4, 4));                // one pixel of overlap, suppressed
    issue_box(make_box(0, 4, 4, 4, 4));                // corner touch only, kept
    issue_box(make_box(0, 4, 4, 0, 0));                // empty box on top of a kept one

    // a full-ratio threshold and the register maximum never suppress
    set_threshold(17'd65536);
    issue_box(make_box(1, 7, 7, 9, 9));
    issue_box(make_box(0, 7, 7, 9, 9));
    set_threshold(17'h1FFFF);
    issue_box(make_box(0, 7, 7, 9, 9));
    issue_box(make_box(0, -2048, 2047, 2047, 0));

    // random phases, each with its own threshold and sender idling
    for (p = 0; p < 6; p++) begin
      case (p)
        0: thr = IOU_THRESHOLD_RESET;
        1: thr = 17'($urandom_range(0, 65536));
        2: thr = 17'd65536;
        3: thr = 17'($urandom_range(0, 17'h1FFFF));
        4: thr = 17'd0;
        default: thr = 17'($urandom_range(16384, 52000));
      endcase
      set_threshold(thr);
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 47;
        default: idle_pct = 17;
      endcase
      items = 0;
      while (items < PHASE_ITEMS) begin
        // mostly short frames; now and then a long one that runs the list full
        if ($urandom_range(99) < 15) begin
          len = $urandom_range(64, 75);
          tiled = 1'b1;
        end else begin
          len = $urandom_range(1, 24);
          tiled = ($urandom_range(99) < 10);
        end
        // a frame without its opening flag keeps adding to the previous list
        run_frame(len, tiled, $urandom_range(99) < 90);
        items += len;
      end
    end

    // drain, then give the block one more walk's worth of cycles
    settle();
    repeat (MAX_KEPT_DEF + 4) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
